@@ rtl/smpq_pkg.sv @@
// Package for the stable max-priority queue.
// Holds sizes, operation codes, payload structs and the cell control struct.
// No dependencies.
package smpq_pkg;

    // Number of cells in the sorted chain
    localparam int DEPTH       = 64;
    // Most results that one serve may return
    localparam int MAX_RESULTS = 64;

    localparam int VALUE_W = 32;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 7;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int REM_W   = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W   = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_SERVE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // One stored entry
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Input item
    typedef struct packed {
        logic [1:0]         operation;
        logic [VALUE_W-1:0] entry_value;
        logic [COUNT_W-1:0] serve_count;
    } in_t;

    // Result item
    typedef struct packed {
        logic [TAG_W-1:0]   served_tag;
        logic [VALUE_W-1:0] served_value;
        logic               last_of_run;
        logic               overflow_seen;
    } out_t;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

@@ rtl/smpq_cell.sv @@
// One cell of the sorted chain: holds a single entry and its valid bit.
// Shifts toward the tail on insert and toward the head on removal.
// Depends on smpq_pkg.
module smpq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  smpq_pkg::cell_ctl_t ctl,
    input  smpq_pkg::entry_t    prev_entry,
    input  logic                prev_valid,
    input  logic                prev_ahead,
    input  smpq_pkg::entry_t    next_entry,
    input  logic                next_valid,
    output smpq_pkg::entry_t    entry,
    output logic                valid,
    output logic                ahead
);

    smpq_pkg::entry_t entry_reg;
    smpq_pkg::entry_t entry_next;
    logic             valid_reg;
    logic             valid_next;

    // New entry goes ahead of an empty cell or a strictly smaller value;
    // equal values keep arrival order since the new tag is always larger.
    assign ahead = !valid_reg || (ctl.new_entry.value > entry_reg.value);

    // Next-state selection
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
        else if (ctl.push)
        begin
            if (prev_ahead)
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
            else if (ahead)
            begin
                entry_next = ctl.new_entry;
                valid_next = 1'b1;
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

@@ rtl/stable_max_priority_queue.sv @@
// Push/clear: a new item may follow in the next cycle.
// Serve of n entries: one result per cycle while the output is not stalled,
// set by the single head removal per cycle in the cell chain; no new input
// is taken until the run ends. Zero-result serves return nothing.
// Reset: all cells empty, occupancy, arrival counter and overflow flag zero.
// Depends on smpq_pkg and smpq_cell.
module stable_max_priority_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  smpq_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output smpq_pkg::out_t out_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SERVE = 2'b10
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [smpq_pkg::OCC_W-1:0]   occ_reg;
    logic [smpq_pkg::OCC_W-1:0]   occ_next;
    logic [smpq_pkg::REM_W-1:0]   rem_reg;
    logic [smpq_pkg::REM_W-1:0]   rem_next;
    logic [smpq_pkg::TAG_W-1:0]   tag_reg;
    logic [smpq_pkg::TAG_W-1:0]   tag_next;
    logic                         exhausted_reg;
    logic                         exhausted_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    smpq_pkg::out_t               out_reg;
    smpq_pkg::out_t               out_next;

    logic                         in_xfer;
    logic                         do_push;
    logic                         push_ok;
    logic                         do_serve;
    logic                         do_clear;
    logic                         pop_en;
    logic [smpq_pkg::CMP_W-1:0]   cnt_lim;
    logic [smpq_pkg::CMP_W-1:0]   occ_ext;
    logic [smpq_pkg::CMP_W-1:0]   serve_n;
    smpq_pkg::cell_ctl_t          ctl;

    smpq_pkg::entry_t             cell_entry [smpq_pkg::DEPTH];
    logic                         cell_valid [smpq_pkg::DEPTH];
    logic                         cell_ahead [smpq_pkg::DEPTH];

    // Input decode
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign do_push  = in_xfer && (in_data.operation == smpq_pkg::OP_PUSH);
    assign do_serve = in_xfer && (in_data.operation == smpq_pkg::OP_SERVE);
    assign do_clear = in_xfer && (in_data.operation == smpq_pkg::OP_CLEAR);
    assign push_ok  = (occ_reg < smpq_pkg::OCC_W'(smpq_pkg::DEPTH)) && !exhausted_reg;

    // Number of results for a serve: clamp to limit, then to occupancy
    always_comb
    begin
        if (in_data.serve_count > smpq_pkg::COUNT_W'(smpq_pkg::MAX_RESULTS))
        begin
            cnt_lim = smpq_pkg::CMP_W'(smpq_pkg::MAX_RESULTS);
        end
        else
        begin
            cnt_lim = smpq_pkg::CMP_W'(in_data.serve_count);
        end
        occ_ext = smpq_pkg::CMP_W'(occ_reg);
        serve_n = (cnt_lim < occ_ext) ? cnt_lim : occ_ext;
    end

    // Head removal when the output register is free or draining
    assign pop_en = (state_reg == ST_SERVE) && (!out_valid_reg || out_ready);

    // Cell control broadcast
    always_comb
    begin
        ctl.push            = do_push && push_ok;
        ctl.pop             = pop_en;
        ctl.clear           = do_clear;
        ctl.new_entry.tag   = tag_reg;
        ctl.new_entry.value = in_data.entry_value;
    end

    // Sorted chain, cell 0 holds the entry served next
    for (genvar i = 0; i < smpq_pkg::DEPTH; i++)
    begin : g_cell
        smpq_pkg::entry_t prev_e;
        logic             prev_v;
        logic             prev_a;
        smpq_pkg::entry_t next_e;
        logic             next_v;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_v = 1'b0;
            assign prev_a = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_v = cell_valid[i-1];
            assign prev_a = cell_ahead[i-1];
        end

        if (i == smpq_pkg::DEPTH - 1)
        begin : g_tail
            assign next_e = '0;
            assign next_v = 1'b0;
        end
        else
        begin : g_body
            assign next_e = cell_entry[i+1];
            assign next_v = cell_valid[i+1];
        end

        smpq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .prev_ahead (prev_a),
            .next_entry (next_e),
            .next_valid (next_v),
            .entry      (cell_entry[i]),
            .valid      (cell_valid[i]),
            .ahead      (cell_ahead[i])
        );
    end

    // Control next state
    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        rem_next       = rem_reg;
        tag_next       = tag_reg;
        exhausted_next = exhausted_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (do_push)
                begin
                    if (push_ok)
                    begin
                        occ_next = occ_reg + 1'b1;
                        if (tag_reg == {smpq_pkg::TAG_W{1'b1}})
                        begin
                            exhausted_next = 1'b1;
                        end
                        else
                        begin
                            tag_next = tag_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (do_clear)
                begin
                    occ_next       = '0;
                    tag_next       = '0;
                    exhausted_next = 1'b0;
                    ovf_next       = 1'b0;
                end
                else if (do_serve && (serve_n != '0))
                begin
                    rem_next   = serve_n[smpq_pkg::REM_W-1:0];
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                if (pop_en)
                begin
                    out_next.served_tag    = cell_entry[0].tag;
                    out_next.served_value  = cell_entry[0].value;
                    out_next.last_of_run   = (rem_reg == smpq_pkg::REM_W'(1));
                    out_next.overflow_seen = ovf_reg;
                    out_valid_next         = 1'b1;
                    occ_next               = occ_reg - 1'b1;
                    rem_next               = rem_reg - 1'b1;
                    if (rem_reg == smpq_pkg::REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            rem_reg       <= '0;
            tag_reg       <= '0;
            exhausted_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rem_reg       <= rem_next;
            tag_reg       <= tag_next;
            exhausted_reg <= exhausted_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Occupancy never exceeds the chain length
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= smpq_pkg::OCC_W'(smpq_pkg::DEPTH))
        else $error("occupancy above depth");

    // Head cell is filled exactly when the queue is not empty
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != '0) == cell_valid[0])
        else $error("head cell valid disagrees with occupancy");

    // A serve run always has results left to give
    a_serve_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SERVE) |-> (rem_reg != '0))
        else $error("serve state with no remaining results");

    // A clear transfer leaves an empty queue and a dropped overflow flag
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (occ_reg == '0) && !ovf_reg && !cell_valid[0])
        else $error("clear did not empty the queue");

endmodule

@@ verif/smpq_scoreboard_pkg.sv @@
// Scoreboard for the stable max-priority queue testbench: predicts served entries
// from accepted transfers and checks each result transfer against them.
// Depends on smpq_pkg.
`timescale 1ns / 1ps

package smpq_scoreboard_pkg;

    // Operation code that the block leaves undefined and ignores
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    // Mismatches printed in full; later ones are only counted
    localparam int         REPORT_LIMIT = 10;

    class serve_order_scoreboard;

        smpq_pkg::entry_t               held[$];
        logic [smpq_pkg::TAG_W-1:0]     next_tag;
        bit                             tags_spent;
        bit                             overflow;
        smpq_pkg::out_t                 due_results[$];
        int unsigned                    failures;

        function new();
            empty_store();
            failures = 0;
        endfunction

        function void empty_store();
            held.delete();
            next_tag   = '0;
            tags_spent = 1'b0;
            overflow   = 1'b0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        // Higher value wins, earlier arrival breaks a tie
        function bit served_first(smpq_pkg::entry_t a, smpq_pkg::entry_t b);
            if (a.value != b.value)
                return a.value > b.value;
            return a.tag < b.tag;
        endfunction

        // Update the shadow queue for one accepted input transfer
        function void note_input(smpq_pkg::in_t item);
            smpq_pkg::entry_t fresh;
            smpq_pkg::out_t   res;
            int unsigned      take;
            int unsigned      best;
            case (item.operation)
                smpq_pkg::OP_PUSH:
                begin
                    if (held.size() >= smpq_pkg::DEPTH || tags_spent)
                        overflow = 1'b1;
                    else
                    begin
                        fresh.tag   = next_tag;
                        fresh.value = item.entry_value;
                        held.push_back(fresh);
                        if (next_tag == '1)
                            tags_spent = 1'b1;
                        else
                            next_tag = next_tag + 1'b1;
                    end
                end
                smpq_pkg::OP_SERVE:
                begin
                    take = 32'(item.serve_count);
                    if (take > smpq_pkg::MAX_RESULTS)
                        take = smpq_pkg::MAX_RESULTS;
                    if (take > unsigned'(held.size()))
                        take = unsigned'(held.size());
                    for (int unsigned k = 0; k < take; k++)
                    begin
                        best = 0;
                        for (int unsigned i = 1; i < unsigned'(held.size()); i++)
                            if (served_first(held[i], held[best]))
                                best = i;
                        res.served_tag    = held[best].tag;
                        res.served_value  = held[best].value;
                        res.last_of_run   = (k == take - 1);
                        res.overflow_seen = overflow;
                        due_results.push_back(res);
                        held.delete(best);
                    end
                end
                smpq_pkg::OP_CLEAR:
                    empty_store();
                default:
                    ;
            endcase
        endfunction

        // Compare one accepted result transfer with the oldest prediction
        function void check_served(smpq_pkg::out_t got);
            smpq_pkg::out_t want;
            bit             bad;
            if (due_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: tag %0d value %h last %b ovf %b",
                             $time, got.served_tag, got.served_value,
                             got.last_of_run, got.overflow_seen);
                return;
            end
            want = due_results.pop_front();
            bad  = (got.served_tag    !== want.served_tag)   ||
                   (got.served_value  !== want.served_value) ||
                   (got.last_of_run   !== want.last_of_run)  ||
                   (got.overflow_seen !== want.overflow_seen);
            if (bad)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $write("[%0t] result mismatch: expected tag %0d value %h last %b ovf %b,",
                           $time, want.served_tag, want.served_value,
                           want.last_of_run, want.overflow_seen);
                    $display(" got tag %0d value %h last %b ovf %b",
                             got.served_tag, got.served_value,
                             got.last_of_run, got.overflow_seen);
                end
            end
        endfunction

    endclass

endpackage

@@ verif/tb_stable_max_priority_queue.sv @@
// Top-level testbench for stable_max_priority_queue: directed, fill/backpressure
// and random phases, checked by serve_order_scoreboard.
// Depends on smpq_pkg, smpq_scoreboard_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_stable_max_priority_queue;

    localparam int RANDOM_ITEMS = 100;
    localparam int TAIL_CYCLES  = 80;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    smpq_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    smpq_pkg::out_t out_data;

    smpq_scoreboard_pkg::serve_order_scoreboard book;
    bit                    quiet;          // no idling on either side when set
    int unsigned           rx_hold_cycles; // long receiver hold-off request

    stable_max_priority_queue i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #20_000_000;
        $display("stable_max_priority_queue regression: fail");
        $finish;
    end

    function automatic smpq_pkg::in_t compose(logic [1:0] op, logic [31:0] value,
                                              logic [6:0] count);
        smpq_pkg::in_t item;
        item.operation   = op;
        item.entry_value = value;
        item.serve_count = count;
        return item;
    endfunction

    // Tie-heavy value picker: half the time one of four corner values, else fully random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'd5;
            default: return $urandom;
        endcase
    endfunction

    function automatic smpq_pkg::in_t random_item();
        int unsigned roll;
        logic [6:0]  count;
        roll = $urandom_range(0, 99);
        if (roll < 58)
            return compose(smpq_pkg::OP_PUSH, pick_value(), 7'($urandom));
        if (roll < 90)
        begin
            case ($urandom_range(0, 9))
                0, 1:    count = 7'($urandom_range(7, 64));
                2:       count = 7'($urandom_range(65, 127));
                default: count = 7'($urandom_range(0, 6));
            endcase
            return compose(smpq_pkg::OP_SERVE, $urandom, count);
        end
        if (roll < 95)
            return compose(smpq_pkg::OP_CLEAR, $urandom, 7'($urandom));
        return compose(smpq_scoreboard_pkg::OP_UNUSED, $urandom, 7'($urandom));
    endfunction

    // Offer one input transfer and wait until it is accepted
    task automatic send_item(input smpq_pkg::in_t item);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.note_input(item);
    endtask

    // Drop valid and wait for all results
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Result side: check accepted transfers, then pick next ready level
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                book.check_served(out_data);
            if (rx_hold_cycles != 0)
            begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        book           = new();
        quiet          = 1'b0;
        rx_hold_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty serve, extremes, ties, zero count, clamp, unused op, tag restart
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd5));
        send_item(compose(smpq_pkg::OP_PUSH, 32'h0000_0000, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_PUSH, 32'd5, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_PUSH, 32'd5, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_PUSH, 32'h0000_0000, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd0));
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd2));
        send_item(compose(smpq_scoreboard_pkg::OP_UNUSED, 32'hFFFF_FFFF, 7'h7F));
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd127));
        send_item(compose(smpq_pkg::OP_PUSH, 32'h8000_0000, 7'h7F));
        send_item(compose(smpq_pkg::OP_CLEAR, $urandom, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd1));
        send_item(compose(smpq_pkg::OP_PUSH, 32'd7, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd64));

        // Fill the store, overflow it, then serve under a long receiver hold-off
        send_item(compose(smpq_pkg::OP_CLEAR, $urandom, 7'($urandom)));
        repeat (smpq_pkg::DEPTH + 2)
            send_item(compose(smpq_pkg::OP_PUSH, pick_value(), 7'($urandom)));
        pause_until_drained();
        rx_hold_cycles = 300;
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd100));
        repeat (10)
            send_item(compose(smpq_pkg::OP_PUSH, pick_value(), 7'($urandom)));
        pause_until_drained();
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd127));
        send_item(compose(smpq_pkg::OP_CLEAR, $urandom, 7'($urandom)));

        // Random traffic, one sender pause, no idling in the last quarter
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                pause_until_drained();
            if (i == (RANDOM_ITEMS * 3) / 4)
                quiet = 1'b1;
            send_item(random_item());
        end
        send_item(compose(smpq_pkg::OP_CLEAR, $urandom, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_PUSH, 32'd1, 7'($urandom)));
        send_item(compose(smpq_pkg::OP_SERVE, $urandom, 7'd1));

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.failures == 0)
            $display("stable_max_priority_queue regression: pass");
        else
            $display("stable_max_priority_queue regression: fail");
        $finish;
    end

endmodule
